// ----- rtl/core/twcw_pkg.sv -----
package twcw_pkg;

   // Screen size defaults
   localparam int SCREEN_ROWS_DEF = 25;
   localparam int SCREEN_COLS_DEF = 80;

   // Field widths
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int SET_W     = 7;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int ADDR_W    = 12;
   localparam int WORK_W    = COL_W + 1;
   localparam int SHIFT_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   // Highest divisor shift for the remainder of a set_row / set_col value
   localparam logic [SHIFT_W-1:0] SHIFT_TOP = SHIFT_W'(SET_W - 1);

   localparam logic [WORK_W-1:0] TAB_STEP = WORK_W'(4);

   // Control characters
   localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

   // Register reset values
   localparam logic [ROW_W-1:0]  WROWS_RST = 5'd25;
   localparam logic [COL_W-1:0]  WCOLS_RST = 7'd80;
   localparam logic [ATTR_W-1:0] ATTR_RST  = 8'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_ROWS = 3'd0,
      CSR_WINDOW_COLS = 3'd1,
      CSR_ROW_ORIGIN  = 3'd2,
      CSR_COL_ORIGIN  = 3'd3,
      CSR_ATTRIBUTE   = 3'd4
   } twcw_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD_ROW,
      ST_MOD_COL,
      ST_ADDR,
      ST_EMIT,
      ST_ADVANCE
   } twcw_state_type;

   // Effective window size, already clamped and nonzero
   typedef struct packed {
      logic [ROW_W-1:0] rows;
      logic [COL_W-1:0] cols;
   } twcw_geom_type;

   // Sequencer strobes toward the address path and output register
   typedef struct packed {
      logic mul_en;
      logic emit;
   } twcw_seq_type;

endpackage

// ----- rtl/core/twcw_cmp_sub.sv -----
module twcw_cmp_sub
   import twcw_pkg::*;
(
   input  logic [WORK_W-1:0]  work,
   input  logic [COL_W-1:0]   divisor,
   input  logic [SHIFT_W-1:0] shift,
   output logic               ge,
   output logic [WORK_W-1:0]  diff
);

   localparam int SHIFTED_W = COL_W + (1 << SHIFT_W);

   logic [SHIFTED_W-1:0] shifted;

   assign shifted = SHIFTED_W'(divisor) << shift;
   assign ge      = SHIFTED_W'(work) >= shifted;
   // Only meaningful when ge is set, so the shifted divisor fits the work width
   assign diff    = work - shifted[WORK_W-1:0];

endmodule

// ----- rtl/core/twcw_addr_calc.sv -----
module twcw_addr_calc
   import twcw_pkg::*;
#(
   parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
   input  logic              clock,
   input  logic              mul_en,
   input  logic [ROW_W-1:0]  row_base,
   input  logic [ROW_W-1:0]  cursor_row,
   input  logic [COL_W-1:0]  col_base,
   input  logic [COL_W-1:0]  cursor_col,
   output logic [ADDR_W-1:0] cell_address
);

   localparam int SCR_COLS_W = $clog2(SCREEN_COLS + 1);
   localparam int PROD_W     = ROW_W + 1 + SCR_COLS_W;
   localparam int SUM_W      = ((PROD_W > COL_W + 1) ? PROD_W : COL_W + 1) + 1;
   localparam logic [SCR_COLS_W-1:0] SCR_COLS_V = SCR_COLS_W'(SCREEN_COLS);

   logic [ROW_W:0]      rsum;
   logic [COL_W:0]      csum_in;
   logic [COL_W:0]      csum_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [SUM_W-1:0]    total;

   assign rsum    = {1'b0, row_base} + {1'b0, cursor_row};
   assign prod_in = PROD_W'(rsum) * PROD_W'(SCR_COLS_V);
   assign csum_in = {1'b0, col_base} + {1'b0, cursor_col};

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
         csum_ff <= csum_in;
      end
   end

   // Two bytes per cell: cell index times two, kept to the address width
   assign total        = SUM_W'(prod_ff) + SUM_W'(csum_ff);
   assign cell_address = ADDR_W'({total, 1'b0});

endmodule

// ----- rtl/core/twcw_ctrl.sv -----
module twcw_ctrl
   import twcw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  twcw_geom_type       geom,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [CHAR_W-1:0]   req_char,
   input  logic [SET_W-1:0]    req_set_row,
   input  logic [SET_W-1:0]    req_set_col,
   input  logic                slot_free,
   output twcw_seq_type        seq,
   output logic [ROW_W-1:0]    cursor_row,
   output logic [COL_W-1:0]    cursor_col,
   output logic [CHAR_W-1:0]   char_code
);

   twcw_state_type state_ff, state_in;

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [WORK_W-1:0]  work_ff, work_in;
   logic [SHIFT_W-1:0] sh_ff, sh_in;
   logic [SET_W-1:0]   setcol_ff, setcol_in;
   logic [CHAR_W-1:0]  char_ff, char_in;

   logic [COL_W-1:0]   unit_div;
   logic [SHIFT_W-1:0] unit_sh;
   logic               unit_ge;
   logic [WORK_W-1:0]  unit_diff;
   logic [WORK_W-1:0]  remainder;
   logic               printable;

   function automatic logic [ROW_W-1:0] row_fwd(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] rows);
      logic [ROW_W:0] nxt;
      nxt = {1'b0, row} + (ROW_W + 1)'(1);
      return (nxt >= {1'b0, rows}) ? '0 : nxt[ROW_W-1:0];
   endfunction

   function automatic logic [ROW_W-1:0] row_bck(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] rows);
      return (row == '0) ? rows - ROW_W'(1) : row - ROW_W'(1);
   endfunction

   twcw_cmp_sub u_unit (
      .work    (work_ff),
      .divisor (unit_div),
      .shift   (unit_sh),
      .ge      (unit_ge),
      .diff    (unit_diff)
   );

   assign remainder = unit_ge ? unit_diff : work_ff;
   assign printable = (req_char != CH_NUL) && (req_char != CH_BS) && (req_char != CH_TAB)
                      && (req_char != CH_NL) && (req_char != CH_CR);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind) begin
                  state_in = ST_MOD_ROW;
               end else if ((req_char == CH_BS && col_ff != '0) || req_char == CH_TAB) begin
                  state_in = ST_ADVANCE;
               end else if (printable) begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_MOD_ROW: begin
            if (sh_ff == '0) state_in = ST_MOD_COL;
         end
         ST_MOD_COL: begin
            if (sh_ff == '0) state_in = ST_IDLE;
         end
         ST_ADDR: state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            if (!unit_ge) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      seq.mul_en = (state_ff == ST_ADDR);
      seq.emit   = (state_ff == ST_EMIT) && slot_free;
      unit_div   = (state_ff == ST_MOD_ROW) ? COL_W'(geom.rows) : geom.cols;
      unit_sh    = (state_ff == ST_ADVANCE) ? '0 : sh_ff;
   end

   // Datapath
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      work_in   = work_ff;
      sh_in     = sh_ff;
      setcol_in = setcol_ff;
      char_in   = char_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               char_in = req_char;
               if (req_kind) begin
                  work_in   = WORK_W'(req_set_row);
                  sh_in     = SHIFT_TOP;
                  setcol_in = req_set_col;
               end else if (req_char == CH_NL) begin
                  row_in = row_fwd(row_ff, geom.rows);
                  col_in = '0;
               end else if (req_char == CH_CR) begin
                  col_in = '0;
               end else if (req_char == CH_BS) begin
                  if (col_ff == '0) begin
                     col_in = geom.cols - COL_W'(1);
                     row_in = row_bck(row_ff, geom.rows);
                  end else begin
                     work_in = WORK_W'(col_ff) - WORK_W'(1);
                  end
               end else if (req_char == CH_TAB) begin
                  work_in = WORK_W'(col_ff) + TAB_STEP;
               end
            end
         end
         ST_MOD_ROW: begin
            if (sh_ff == '0) begin
               row_in  = remainder[ROW_W-1:0];
               work_in = WORK_W'(setcol_ff);
               sh_in   = SHIFT_TOP;
            end else begin
               work_in = remainder;
               sh_in   = sh_ff - SHIFT_W'(1);
            end
         end
         ST_MOD_COL: begin
            if (sh_ff == '0) begin
               col_in = remainder[COL_W-1:0];
            end else begin
               work_in = remainder;
               sh_in   = sh_ff - SHIFT_W'(1);
            end
         end
         ST_ADDR: begin
         end
         ST_EMIT: begin
            if (slot_free) work_in = WORK_W'(col_ff) + WORK_W'(1);
         end
         ST_ADVANCE: begin
            if (unit_ge) begin
               work_in = unit_diff;
               row_in  = row_fwd(row_ff, geom.rows);
            end else begin
               col_in = work_ff[COL_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      sh_ff     <= sh_in;
      setcol_ff <= setcol_in;
      char_ff   <= char_in;
   end

   assign cursor_row = row_ff;
   assign cursor_col = col_ff;
   assign char_code  = char_ff;

endmodule

// ----- rtl/core/text_window_cursor_writer_unit.sv -----
// Text-mode console writer for a window on a SCREEN_ROWS x SCREEN_COLS character
// screen. Each req transfer carries one character (tuser low) or one cursor-set
// command (tuser high); one item is worked at a time and req_tready stays low
// until it is done. NUL, return, newline and backspace from column 0 are done
// in the idle state. A printable character passes ST_ADDR and ST_EMIT (held
// there while the rsp register is still full), then ST_ADVANCE with one subtract
// per row wrap of the column, and emits one rsp transfer with the byte
// address, character and attribute of the cell. Tab and other backspaces go
// to ST_ADVANCE, one subtract per row wrap; with a one-column window a wrap count
// can reach the column plus four. The row and column remainders of a cursor
// set each run seven restoring steps. All of this goes through one shared
// compare/subtract unit. The rsp register lets a finished write wait
// while the next item is accepted. Write csr registers only while idle.
module text_window_cursor_writer_unit
   import twcw_pkg::*;
#(
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
   parameter int SCREEN_COLS = SCREEN_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // Item input
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // char_code[7:0], set_row[14:8], set_col[21:15]
   input  logic                 req_tuser,   // kind
   // Video write output
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // cell_address[11:0], cell_char[19:12],
                                             // cell_attr[27:20]
   // Register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam logic [6:0] SCR_ROWS_V = 7'(SCREEN_ROWS);
   localparam logic [7:0] SCR_COLS_V = 8'(SCREEN_COLS);

   logic [ROW_W-1:0]  wrows_ff;
   logic [COL_W-1:0]  wcols_ff;
   logic [ROW_W-1:0]  rorg_ff;
   logic [COL_W-1:0]  corg_ff;
   logic [ATTR_W-1:0] attr_ff;

   logic [ROW_W-1:0]  rows_clamp;
   logic [COL_W-1:0]  cols_clamp;
   logic [ROW_W-1:0]  row_base;
   logic [COL_W-1:0]  col_base;
   twcw_geom_type     geom;
   twcw_seq_type      seq;

   logic [ROW_W-1:0]  cursor_row;
   logic [COL_W-1:0]  cursor_col;
   logic [CHAR_W-1:0] char_code;
   logic [ADDR_W-1:0] cell_address;
   logic              slot_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   // Register file: always ready, indexes past the list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrows_ff <= WROWS_RST;
         wcols_ff <= WCOLS_RST;
         rorg_ff  <= '0;
         corg_ff  <= '0;
         attr_ff  <= ATTR_RST;
      end else if (csr_valid) begin
         unique case (twcw_csr_type'(csr_index))
            CSR_WINDOW_ROWS: wrows_ff <= csr_data[ROW_W-1:0];
            CSR_WINDOW_COLS: wcols_ff <= csr_data[COL_W-1:0];
            CSR_ROW_ORIGIN:  rorg_ff  <= csr_data[ROW_W-1:0];
            CSR_COL_ORIGIN:  corg_ff  <= csr_data[COL_W-1:0];
            CSR_ATTRIBUTE:   attr_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Clamp the window to the screen, zero size counts as one
   assign rows_clamp = ({2'b0, wrows_ff} > SCR_ROWS_V) ? SCR_ROWS_V[ROW_W-1:0] : wrows_ff;
   assign cols_clamp = ({1'b0, wcols_ff} > SCR_COLS_V) ? SCR_COLS_V[COL_W-1:0] : wcols_ff;
   assign geom.rows  = (rows_clamp == '0) ? ROW_W'(1) : rows_clamp;
   assign geom.cols  = (cols_clamp == '0) ? COL_W'(1) : cols_clamp;

   // Drop an origin whose window reaches the screen edge (raw register sizes)
   assign row_base = (({2'b0, rorg_ff} + {2'b0, wrows_ff}) >= SCR_ROWS_V) ? '0 : rorg_ff;
   assign col_base = (({1'b0, corg_ff} + {1'b0, wcols_ff}) >= SCR_COLS_V) ? '0 : corg_ff;

   twcw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_char    (req_tdata[7:0]),
      .req_set_row (req_tdata[14:8]),
      .req_set_col (req_tdata[21:15]),
      .slot_free   (slot_free),
      .seq         (seq),
      .cursor_row  (cursor_row),
      .cursor_col  (cursor_col),
      .char_code   (char_code)
   );

   twcw_addr_calc #(
      .SCREEN_COLS (SCREEN_COLS)
   ) u_addr (
      .clock        (clock),
      .mul_en       (seq.mul_en),
      .row_base     (row_base),
      .cursor_row   (cursor_row),
      .col_base     (col_base),
      .cursor_col   (cursor_col),
      .cell_address (cell_address)
   );

   // Output register: load on emit, hold until the rsp transfer
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0, attr_ff, char_code, cell_address};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- verif/text_window_cursor_writer_unit_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the text window cursor writer. A shadow of the
// cursor and window registers predicts each video write; results are matched
// in order against that prediction as they leave the rsp channel.
module text_window_cursor_writer_unit_tb
   import twcw_pkg::*;
();

   // Cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT   = 3000;
   // Worst-case drain time of one item that yields no write (long tab wrap)
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic [ADDR_W-1:0] address;
      logic [CHAR_W-1:0] code;
      logic [ATTR_W-1:0] attr;
   } cell_write_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;   // char_code[7:0], set_row[14:8], set_col[21:15]
   logic                 req_tuser;   // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;   // cell_address[11:0], cell_char[19:12],
                                      // cell_attr[27:20]
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   // Shadow copy of the window registers and the cursor
   logic [ROW_W-1:0]  win_rows;
   logic [COL_W-1:0]  win_cols;
   logic [ROW_W-1:0]  org_row;
   logic [COL_W-1:0]  org_col;
   logic [ATTR_W-1:0] cell_attr;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;

   // Video writes predicted but not yet seen on rsp, oldest first
   cell_write_type pending_writes[$];

   int fail_count   = 0;
   int quiet_cycles = 0;
   int rsp_hold_len = 0;
   bit idle_en      = 1'b1;

   text_window_cursor_writer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Cursor and address prediction
   // ---------------------------------------------------------------------

   // Window height in use: clamp to the screen, a zero size counts as one
   function automatic int rows_in_use();
      int r;
      r = (win_rows > SCREEN_ROWS_DEF) ? SCREEN_ROWS_DEF : int'(win_rows);
      return (r == 0) ? 1 : r;
   endfunction

   function automatic int cols_in_use();
      int c;
      c = (win_cols > SCREEN_COLS_DEF) ? SCREEN_COLS_DEF : int'(win_cols);
      return (c == 0) ? 1 : c;
   endfunction

   // Step down one row; anything at or past the last row goes back to row 0
   function automatic void row_down(int rows);
      cur_row = (int'(cur_row) + 1 >= rows) ? '0 : cur_row + 1'b1;
   endfunction

   // Move the cursor by n cells, one row step per column wrap. The column can
   // sit far outside a window that shrank, so wrap one column count at a time.
   function automatic void cursor_move(int n);
      int rows;
      int cols;
      int c;
      rows = rows_in_use();
      cols = cols_in_use();
      c    = int'(cur_col) + n;
      while (c < 0) begin
         c += cols;
         cur_row = (cur_row == '0) ? ROW_W'(rows - 1) : cur_row - 1'b1;
      end
      while (c >= cols) begin
         c -= cols;
         row_down(rows);
      end
      cur_col = COL_W'(c);
   endfunction

   // Apply one accepted item to the shadow cursor and queue its video write
   function automatic void predict_item(logic kind, logic [CHAR_W-1:0] ch,
                                        logic [SET_W-1:0] set_r,
                                        logic [SET_W-1:0] set_c);
      int rows;
      int cols;
      int r0;
      int c0;
      int addr;
      cell_write_type w;
      rows = rows_in_use();
      cols = cols_in_use();
      if (kind) begin
         cur_row = ROW_W'(int'(set_r) % rows);
         cur_col = COL_W'(int'(set_c) % cols);
      end else begin
         case (ch)
            CH_NL: begin
               row_down(rows);
               cur_col = '0;
            end
            CH_CR:  cur_col = '0;
            CH_BS:  cursor_move(-1);
            CH_TAB: cursor_move(int'(TAB_STEP));
            CH_NUL: ;
            default: begin
               // Origin drops to zero when the raw origin plus raw size hits the edge
               r0 = (int'(org_row) + int'(win_rows) >= SCREEN_ROWS_DEF) ? 0 : int'(org_row);
               c0 = (int'(org_col) + int'(win_cols) >= SCREEN_COLS_DEF) ? 0 : int'(org_col);
               addr = ((r0 + int'(cur_row)) * SCREEN_COLS_DEF + c0 + int'(cur_col)) * 2;
               w.address = ADDR_W'(addr);
               w.code    = ch;
               w.attr    = cell_attr;
               pending_writes.push_back(w);
               cursor_move(1);
            end
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one item and wait for its transfer. tvalid stays high on return so
   // that a following item goes out back to back; settle drops it.
   task automatic send_item(input logic kind, input logic [CHAR_W-1:0] ch,
                            input logic [SET_W-1:0] set_r, input logic [SET_W-1:0] set_c);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, set_c, set_r, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(kind, ch, set_r, set_c);
      @(negedge clock);
   endtask

   // Unused set fields carry random bits; the block must ignore them
   task automatic put_char(input logic [CHAR_W-1:0] ch);
      send_item(1'b0, ch, SET_W'($urandom_range(0, 127)), SET_W'($urandom_range(0, 127)));
   endtask

   task automatic set_cursor(input logic [SET_W-1:0] set_r, input logic [SET_W-1:0] set_c);
      send_item(1'b1, CHAR_W'($urandom_range(0, 255)), set_r, set_c);
   endtask

   // Drop tvalid, wait for every predicted write, then let a long wrap finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input twcw_csr_type idx, input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WINDOW_ROWS: win_rows  = value[ROW_W-1:0];
         CSR_WINDOW_COLS: win_cols  = value[COL_W-1:0];
         CSR_ROW_ORIGIN:  org_row   = value[ROW_W-1:0];
         CSR_COL_ORIGIN:  org_col   = value[COL_W-1:0];
         CSR_ATTRIBUTE:   cell_attr = value[ATTR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reprogram the whole window once the block has gone idle
   task automatic configure(input int rows, input int cols, input int row_org,
                            input int col_org, input int attr);
      settle();
      csr_write(CSR_WINDOW_ROWS, CSR_DAT_W'(rows));
      csr_write(CSR_WINDOW_COLS, CSR_DAT_W'(cols));
      csr_write(CSR_ROW_ORIGIN, CSR_DAT_W'(row_org));
      csr_write(CSR_COL_ORIGIN, CSR_DAT_W'(col_org));
      csr_write(CSR_ATTRIBUTE, CSR_DAT_W'(attr));
   endtask

   // Register value leaning toward the extremes and the nominal screen bound
   function automatic int pick_reg_value(int reg_max, int nominal);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 1;
         2:       return reg_max;
         3:       return nominal;
         default: return $urandom_range(0, reg_max);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every control code, byte extremes, wraps at both corners of the window
   task automatic test_basic_controls();
      put_char(8'h41);
      put_char(8'hFF);
      put_char(8'h01);
      put_char(CH_TAB);
      put_char(CH_BS);
      put_char(CH_CR);
      put_char(CH_NL);
      put_char(CH_NUL);
      put_char(8'h80);
      set_cursor(7'd127, 7'd127);
      put_char(8'h7F);
      set_cursor(7'd24, 7'd79);
      put_char(8'h23);              // last cell, wraps to the top-left
      put_char(CH_BS);              // back from the top-left to the last cell
      put_char(8'h7A);
      set_cursor(7'd24, 7'd78);
      put_char(CH_TAB);             // tab across the bottom-right corner
      put_char(8'h54);
      set_cursor(7'd0, 7'd0);
      put_char(CH_BS);
      set_cursor(7'd24, 7'd5);
      put_char(CH_NL);              // newline from the last row
      put_char(8'h4E);
   endtask

   // Leave the cursor far outside a window that then shrinks, for each step kind
   task automatic test_shrunken_window();
      logic [CHAR_W-1:0] steps[5];
      steps = '{CH_TAB, CH_NL, CH_BS, CH_CR, 8'h53};
      foreach (steps[i]) begin
         configure(25, 80, 0, 0, 7);
         set_cursor(7'd24, 7'd79);
         configure(3, 5, 2, 1, 8'hA5);
         put_char(steps[i]);
         put_char(8'h42);
      end
   endtask

   // Zero size counts as one; large origins with a cursor far off overflow the address
   task automatic test_zero_window_and_overflow();
      configure(25, 80, 0, 0, 7);
      set_cursor(7'd24, 7'd79);
      configure(0, 0, 24, 79, 0);
      put_char(8'h4F);
      put_char(CH_TAB);
      put_char(CH_BS);
      put_char(CH_NL);
      set_cursor(7'd127, 7'd127);
      put_char(8'h50);
      configure(31, 127, 31, 127, 255);
      set_cursor(7'd127, 7'd127);
      put_char(8'hFE);
      put_char(CH_TAB);
      configure(1, 1, 0, 0, 0);
      put_char(8'h31);
      put_char(CH_BS);
      put_char(8'h32);
   endtask

   // Origin stays when origin plus size is short of the edge, else falls to 0
   task automatic test_origin_rules();
      configure(10, 20, 15, 60, 8'h1E);
      repeat (3) put_char(8'h61);
      put_char(CH_NL);
      put_char(8'h62);
      configure(10, 20, 14, 59, 8'hE1);
      set_cursor(7'd9, 7'd17);
      put_char(8'h63);
      put_char(CH_TAB);
      put_char(8'h64);
      put_char(CH_BS);
      put_char(CH_BS);
      put_char(8'h65);
   endtask

   // Hold rsp off for a long stretch while writes keep coming, so req backs up
   task automatic test_full_rsp_stall();
      configure(25, 80, 0, 0, 7);
      idle_en      = 1'b0;
      rsp_hold_len = 300;
      repeat (10) begin
         put_char(8'($urandom_range(32, 126)));
         put_char(CH_TAB);
      end
      idle_en = 1'b1;
   endtask

   task automatic random_item();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)      put_char(8'($urandom_range(0, 255)));
      else if (sel < 66) put_char(CH_NL);
      else if (sel < 70) put_char(CH_CR);
      else if (sel < 76) put_char(CH_BS);
      else if (sel < 84) put_char(CH_TAB);
      else if (sel < 87) put_char(CH_NUL);
      else               set_cursor(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
   endtask

   task automatic test_random(input int count, input bit steady);
      configure(pick_reg_value(31, 25), pick_reg_value(127, 80),
                pick_reg_value(31, 24), pick_reg_value(127, 79),
                pick_reg_value(255, 255));
      idle_en = !steady;
      repeat (count) random_item();
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall bursts, plus the long hold on request
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold_len = 0;
            rsp_tready <= 1'b1;
         end else if (idle_en && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Match each rsp transfer with the oldest predicted write
   always @(posedge clock) begin : write_check
      cell_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $error("cell write with none expected: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_tdata[11:0] !== want.address) begin
               $error("cell_address: expected %0d, actual %0d", want.address, rsp_tdata[11:0]);
               fail_count++;
            end
            if (rsp_tdata[19:12] !== want.code) begin
               $error("cell_char: expected %0d, actual %0d", want.code, rsp_tdata[19:12]);
               fail_count++;
            end
            if (rsp_tdata[27:20] !== want.attr) begin
               $error("cell_attr: expected %0d, actual %0d", want.attr, rsp_tdata[27:20]);
               fail_count++;
            end
         end
      end
   end

   // Hang detection: count cycles in which no channel makes a transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_WINDOW_ROWS;
      csr_data   = '0;
      win_rows   = WROWS_RST;
      win_cols   = WCOLS_RST;
      org_row    = '0;
      org_col    = '0;
      cell_attr  = ATTR_RST;
      cur_row    = '0;
      cur_col    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_controls();
      test_shrunken_window();
      test_zero_window_and_overflow();
      test_origin_rules();
      test_full_rsp_stall();
      repeat (5) test_random(110, 1'b0);
      // Final stretch runs with no random req gaps and rsp always ready
      test_random(110, 1'b1);

      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
